// ===== sv/pdc_pkg.sv =====
// ---------------------------------------------------------------------------
// pdc_pkg
// Shared types and constants for the presence debounce calibrator.
// ---------------------------------------------------------------------------
package pdc_pkg;

    // Request opcodes
    typedef enum logic [2:0] {
        OP_TICK      = 3'd0,
        OP_CAL_START = 3'd1,
        OP_CAL_STOP  = 3'd2,
        OP_SET_THR   = 3'd3,
        OP_RESTORE   = 3'd4
    } t_opcode;

    // Event codes reported with each result
    localparam logic [1:0] EV_NONE     = 2'd0;
    localparam logic [1:0] EV_CAL_GO   = 2'd1;
    localparam logic [1:0] EV_CAL_DONE = 2'd2;
    localparam logic [1:0] EV_CAL_FAIL = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_SAMPLE_PERIOD = 3'd0;
    localparam logic [2:0] CFG_DEBOUNCE      = 3'd1;
    localparam logic [2:0] CFG_CAL_DURATION  = 3'd2;
    localparam logic [2:0] CFG_CAL_PERIOD    = 3'd3;
    localparam logic [2:0] CFG_CAL_MIN_SAMP  = 3'd4;
    localparam logic [2:0] CFG_DEFAULT_THR   = 3'd5;

    // Register reset values
    localparam logic [15:0] RST_SAMPLE_PERIOD = 16'd50;
    localparam logic [15:0] RST_DEBOUNCE      = 16'd200;
    localparam logic [15:0] RST_CAL_DURATION  = 16'd3000;
    localparam logic [15:0] RST_CAL_PERIOD    = 16'd20;
    localparam logic [15:0] RST_CAL_MIN_SAMP  = 16'd10;
    localparam logic [31:0] RST_DEFAULT_THR   = 32'd40000;

    // Sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SEED,
        ST_CAL_AGE,
        ST_CAL_END,
        ST_CAL_GAP,
        ST_CAL_PER,
        ST_CAL_MIN,
        ST_CAL_MAX,
        ST_CAL_SUM,
        ST_NRM_AGE,
        ST_NRM_PER,
        ST_NRM_CMP,
        ST_DEB_AGE,
        ST_DEB_CMP,
        ST_WIN_OK,
        ST_DIV,
        ST_THR_DIFF,
        ST_THR_ADD,
        ST_THR_INC,
        ST_APPLY,
        ST_DONE
    } t_state;

endpackage

// ===== sv/presence_debounce_calibrator_core.sv =====
// ---------------------------------------------------------------------------
// presence_debounce_calibrator_core
// Debounced touch presence detector with min/max threshold calibration.
// ---------------------------------------------------------------------------
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+-----------------------------
//  request  | in        | i_in_valid / o_in_ready   | opcode, raw_sample,
//           |           |                           | new_threshold
//  result   | out       | o_out_valid / i_out_ready | present ... start_refused
//  config   | in        | i_cfg_we (no wait)        | i_cfg_index, i_cfg_wdata
//
//  Each request is worked through by a small sequencer around one shared
//  add/subtract unit: one compare or add per cycle. A tick that closes a
//  calibration window with samples in it also runs the restoring divider
//  for the average, one quotient bit per cycle. o_in_ready is high only in
//  idle. A finished result sits in the output register; the next request
//  is taken while it waits, and the sequencer holds its last step only if
//  the previous result has still not gone.
//  Reset is synchronous, active low, and needs no clearing pass.
// ---------------------------------------------------------------------------
module presence_debounce_calibrator_core #(
    parameter int RAW_BITS   = 32,
    parameter int COUNT_BITS = 17
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_opcode,
    input  logic [31:0] i_raw_sample,
    input  logic [31:0] i_new_threshold,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_present,
    output logic        o_raw_present,
    output logic [1:0]  o_event_code,
    output logic        o_calibrating,
    output logic [31:0] o_threshold_now,
    output logic        o_cal_ok,
    output logic [31:0] o_cal_min,
    output logic [31:0] o_cal_max,
    output logic [31:0] o_cal_avg,
    output logic [16:0] o_cal_samples,
    output logic        o_start_refused,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);

    localparam int SUM_BITS = RAW_BITS + COUNT_BITS;
    // shared unit width: widest operand plus one for carry / borrow
    localparam int W        = ((SUM_BITS > 32) ? SUM_BITS : 32) + 1;
    localparam int DIV_CW   = $clog2(SUM_BITS);
    localparam logic [31:0] RAW_MASK = 32'((64'd1 << RAW_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // ---------------- configuration registers ----------------
    logic [15:0] r_cfg_period, r_cfg_debounce, r_cfg_cal_dur, r_cfg_cal_per;
    logic [15:0] r_cfg_min_samp;
    logic [31:0] r_cfg_default;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_period   <= pdc_pkg::RST_SAMPLE_PERIOD;
            r_cfg_debounce <= pdc_pkg::RST_DEBOUNCE;
            r_cfg_cal_dur  <= pdc_pkg::RST_CAL_DURATION;
            r_cfg_cal_per  <= pdc_pkg::RST_CAL_PERIOD;
            r_cfg_min_samp <= pdc_pkg::RST_CAL_MIN_SAMP;
            r_cfg_default  <= pdc_pkg::RST_DEFAULT_THR;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pdc_pkg::CFG_SAMPLE_PERIOD: r_cfg_period   <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_DEBOUNCE:      r_cfg_debounce <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_CAL_DURATION:  r_cfg_cal_dur  <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_CAL_PERIOD:    r_cfg_cal_per  <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_CAL_MIN_SAMP:  r_cfg_min_samp <= i_cfg_wdata[15:0];
                pdc_pkg::CFG_DEFAULT_THR:   r_cfg_default  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- detector state ----------------
    pdc_pkg::t_state r_state, n_state;

    logic [31:0]          r_ms;            // millisecond count, "now"
    logic                 r_seeded;
    logic [31:0]          r_last_sample;
    logic [31:0]          r_last_change;
    logic [RAW_BITS-1:0]  r_last_raw;
    logic                 r_raw_dec;
    logic                 r_present;
    logic [31:0]          r_thr;
    logic                 r_cal_run;
    logic [31:0]          r_cal_start;
    logic [31:0]          r_cal_last;
    logic                 r_cal_have;
    logic [RAW_BITS-1:0]  r_run_min;
    logic [RAW_BITS-1:0]  r_run_max;
    logic [SUM_BITS-1:0]  r_run_sum;       // holds the quotient while dividing
    logic [COUNT_BITS-1:0] r_run_count;
    // last calibration
    logic                 r_res_ok;
    logic [RAW_BITS-1:0]  r_res_min, r_res_max;
    logic [31:0]          r_res_avg;
    logic [COUNT_BITS-1:0] r_res_count;
    // per request
    logic [RAW_BITS-1:0]  r_samp;
    logic [1:0]           r_event;
    logic                 r_refused;
    // sequencer scratch
    logic [31:0]          r_acc;
    logic                 r_flag;
    logic [31:0]          r_cand;
    logic [COUNT_BITS:0]  r_rem;
    logic [DIV_CW-1:0]    r_div_cnt;

    // ---------------- shared add/subtract unit ----------------
    logic [W-1:0] alu_a, alu_b;
    logic         alu_sub;
    logic [W:0]   alu_y;
    logic         alu_ge;                  // a >= b on a subtract

    assign alu_y  = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (W+1)'(alu_sub);
    assign alu_ge = alu_y[W];

    logic                in_accept, out_load;
    logic [RAW_BITS-1:0] samp_in;
    logic [COUNT_BITS:0] div_shift;
    logic                div_q;
    logic [SUM_BITS-1:0] div_next;
    logic [SUM_BITS+31:0] avg_wide;
    logic [COUNT_BITS+16:0] cnt_wide;

    assign o_in_ready = (r_state == pdc_pkg::ST_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign samp_in    = RAW_BITS'(i_raw_sample & RAW_MASK);

    // restoring division step: shift in the next dividend bit, try subtracting
    assign div_shift = {r_rem[COUNT_BITS-1:0], r_run_sum[SUM_BITS-1]};
    assign div_q     = alu_ge;
    assign div_next  = {r_run_sum[SUM_BITS-2:0], div_q};
    assign avg_wide  = {32'd0, div_next};

    // ---------------- state register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pdc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- next state and unit operands ----------------
    always_comb begin
        n_state  = r_state;
        alu_a    = '0;
        alu_b    = '0;
        alu_sub  = 1'b1;
        out_load = 1'b0;
        case (r_state)
            pdc_pkg::ST_IDLE: begin
                if (in_accept) begin
                    case (i_opcode)
                        pdc_pkg::OP_TICK: begin
                            if (!r_seeded)      n_state = pdc_pkg::ST_SEED;
                            else if (r_cal_run) n_state = pdc_pkg::ST_CAL_AGE;
                            else                n_state = pdc_pkg::ST_NRM_AGE;
                        end
                        pdc_pkg::OP_SET_THR,
                        pdc_pkg::OP_RESTORE: n_state = pdc_pkg::ST_APPLY;
                        default:             n_state = pdc_pkg::ST_DONE;
                    endcase
                end
            end
            pdc_pkg::ST_SEED: begin
                // sample > threshold
                alu_a   = W'(r_thr);
                alu_b   = W'(r_last_raw);
                n_state = pdc_pkg::ST_DONE;
            end
            pdc_pkg::ST_CAL_AGE: begin
                alu_a   = W'(r_ms);
                alu_b   = W'(r_cal_start);
                n_state = pdc_pkg::ST_CAL_END;
            end
            pdc_pkg::ST_CAL_END: begin
                alu_a = W'(r_acc);
                alu_b = W'(r_cfg_cal_dur);
                if (alu_ge)          n_state = pdc_pkg::ST_WIN_OK;
                else if (r_cal_have) n_state = pdc_pkg::ST_CAL_GAP;
                else                 n_state = pdc_pkg::ST_CAL_MIN;
            end
            pdc_pkg::ST_CAL_GAP: begin
                alu_a   = W'(r_ms);
                alu_b   = W'(r_cal_last);
                n_state = pdc_pkg::ST_CAL_PER;
            end
            pdc_pkg::ST_CAL_PER: begin
                alu_a   = W'(r_acc);
                alu_b   = W'(r_cfg_cal_per);
                n_state = alu_ge ? pdc_pkg::ST_CAL_MIN : pdc_pkg::ST_DONE;
            end
            pdc_pkg::ST_CAL_MIN: begin
                alu_a   = W'(r_samp);
                alu_b   = W'(r_run_min);
                n_state = pdc_pkg::ST_CAL_MAX;
            end
            pdc_pkg::ST_CAL_MAX: begin
                alu_a   = W'(r_run_max);
                alu_b   = W'(r_samp);
                n_state = (r_run_count != COUNT_MAX) ? pdc_pkg::ST_CAL_SUM
                                                     : pdc_pkg::ST_DONE;
            end
            pdc_pkg::ST_CAL_SUM: begin
                alu_a   = W'(r_run_sum);
                alu_b   = W'(r_samp);
                alu_sub = 1'b0;
                n_state = pdc_pkg::ST_DONE;
            end
            pdc_pkg::ST_NRM_AGE: begin
                alu_a   = W'(r_ms);
                alu_b   = W'(r_last_sample);
                n_state = pdc_pkg::ST_NRM_PER;
            end
            pdc_pkg::ST_NRM_PER: begin
                alu_a   = W'(r_acc);
                alu_b   = W'(r_cfg_period);
                n_state = alu_ge ? pdc_pkg::ST_NRM_CMP : pdc_pkg::ST_DONE;
            end
            pdc_pkg::ST_NRM_CMP: begin
                alu_a   = W'(r_thr);
                alu_b   = W'(r_samp);
                n_state = pdc_pkg::ST_DEB_AGE;
            end
            pdc_pkg::ST_DEB_AGE: begin
                alu_a   = W'(r_ms);
                alu_b   = W'(r_last_change);
                n_state = pdc_pkg::ST_DEB_CMP;
            end
            pdc_pkg::ST_DEB_CMP: begin
                alu_a   = W'(r_acc);
                alu_b   = W'(r_cfg_debounce);
                n_state = pdc_pkg::ST_DONE;
            end
            pdc_pkg::ST_WIN_OK: begin
                alu_a = W'(r_run_count);
                alu_b = W'(r_cfg_min_samp);
                if (r_run_count != '0) n_state = pdc_pkg::ST_DIV;
                else if (alu_ge)       n_state = pdc_pkg::ST_THR_DIFF;
                else                   n_state = pdc_pkg::ST_DONE;
            end
            pdc_pkg::ST_DIV: begin
                alu_a = W'(div_shift);
                alu_b = W'(r_run_count);
                if (r_div_cnt == '0) begin
                    n_state = r_res_ok ? pdc_pkg::ST_THR_DIFF : pdc_pkg::ST_DONE;
                end
            end
            pdc_pkg::ST_THR_DIFF: begin
                alu_a   = W'(r_run_max);
                alu_b   = W'(r_run_min);
                n_state = pdc_pkg::ST_THR_ADD;
            end
            pdc_pkg::ST_THR_ADD: begin
                alu_a   = W'(r_run_max);
                alu_b   = W'(r_acc);
                alu_sub = 1'b0;
                // spread of zero, max below min or 32-bit overflow: use max+1
                if (r_flag || (r_acc == '0) || alu_y[32]) n_state = pdc_pkg::ST_THR_INC;
                else                                     n_state = pdc_pkg::ST_APPLY;
            end
            pdc_pkg::ST_THR_INC: begin
                alu_a   = W'(r_run_max);
                alu_b   = W'(1'b1);
                alu_sub = 1'b0;
                n_state = pdc_pkg::ST_APPLY;
            end
            pdc_pkg::ST_APPLY: begin
                alu_a   = W'(r_cand);
                alu_b   = W'(r_last_raw);
                n_state = pdc_pkg::ST_DONE;
            end
            pdc_pkg::ST_DONE: begin
                if (!o_out_valid || i_out_ready) begin
                    out_load = 1'b1;
                    n_state  = pdc_pkg::ST_IDLE;
                end
            end
            default: n_state = pdc_pkg::ST_IDLE;
        endcase
    end

    // ---------------- datapath ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms          <= '0;
            r_seeded      <= 1'b0;
            r_last_sample <= '0;
            r_last_change <= '0;
            r_last_raw    <= '0;
            r_raw_dec     <= 1'b0;
            r_present     <= 1'b0;
            r_thr         <= pdc_pkg::RST_DEFAULT_THR;
            r_cal_run     <= 1'b0;
            r_cal_start   <= '0;
            r_cal_last    <= '0;
            r_cal_have    <= 1'b0;
            r_run_min     <= '1;
            r_run_max     <= '0;
            r_run_sum     <= '0;
            r_run_count   <= '0;
            r_res_ok      <= 1'b0;
            r_res_min     <= '0;
            r_res_max     <= '0;
            r_res_avg     <= '0;
            r_res_count   <= '0;
            r_event       <= pdc_pkg::EV_NONE;
            r_refused     <= 1'b0;
        end else begin
            case (r_state)
                pdc_pkg::ST_IDLE: begin
                    if (in_accept) begin
                        r_samp    <= samp_in;
                        r_event   <= pdc_pkg::EV_NONE;
                        r_refused <= 1'b0;
                        case (i_opcode)
                            pdc_pkg::OP_TICK: begin
                                r_ms <= r_ms + 32'd1;
                                if (!r_seeded) begin
                                    r_seeded      <= 1'b1;
                                    r_last_raw    <= samp_in;
                                    r_last_change <= r_ms + 32'd1;
                                    r_last_sample <= r_ms + 32'd1;
                                end
                            end
                            pdc_pkg::OP_CAL_START: begin
                                if (r_cal_run) begin
                                    r_refused <= 1'b1;
                                end else begin
                                    r_cal_run   <= 1'b1;
                                    r_cal_start <= r_ms;
                                    r_cal_last  <= '0;
                                    r_cal_have  <= 1'b0;
                                    r_run_min   <= '1;
                                    r_run_max   <= '0;
                                    r_run_sum   <= '0;
                                    r_run_count <= '0;
                                    r_event     <= pdc_pkg::EV_CAL_GO;
                                end
                            end
                            pdc_pkg::OP_CAL_STOP: r_cal_run <= 1'b0;
                            pdc_pkg::OP_SET_THR:  r_cand    <= i_new_threshold;
                            pdc_pkg::OP_RESTORE:  r_cand    <= r_cfg_default;
                            default: ;
                        endcase
                    end
                end
                pdc_pkg::ST_SEED: begin
                    r_raw_dec <= !alu_ge;
                    r_present <= !alu_ge;
                end
                pdc_pkg::ST_CAL_AGE,
                pdc_pkg::ST_CAL_GAP,
                pdc_pkg::ST_NRM_AGE,
                pdc_pkg::ST_DEB_AGE: r_acc <= alu_y[31:0];
                pdc_pkg::ST_CAL_MIN: begin
                    r_cal_have <= 1'b1;
                    r_cal_last <= r_ms;
                    r_last_raw <= r_samp;
                    if (!alu_ge) r_run_min <= r_samp;
                end
                pdc_pkg::ST_CAL_MAX: begin
                    if (!alu_ge) r_run_max <= r_samp;
                end
                pdc_pkg::ST_CAL_SUM: begin
                    r_run_sum   <= alu_y[SUM_BITS-1:0];
                    r_run_count <= r_run_count + COUNT_BITS'(1);
                end
                pdc_pkg::ST_NRM_CMP: begin
                    r_last_sample <= r_ms;
                    r_last_raw    <= r_samp;
                    if (!alu_ge != r_raw_dec) begin
                        r_raw_dec     <= !alu_ge;
                        r_last_change <= r_ms;
                    end
                end
                pdc_pkg::ST_DEB_CMP: begin
                    if (alu_ge) r_present <= r_raw_dec;
                end
                pdc_pkg::ST_WIN_OK: begin
                    r_cal_run   <= 1'b0;
                    r_res_ok    <= alu_ge;
                    r_res_count <= r_run_count;
                    r_res_min   <= (r_run_count != '0) ? r_run_min : '0;
                    r_res_max   <= (r_run_count != '0) ? r_run_max : '0;
                    r_res_avg   <= '0;
                    r_event     <= alu_ge ? pdc_pkg::EV_CAL_DONE : pdc_pkg::EV_CAL_FAIL;
                    r_rem       <= '0;
                    r_div_cnt   <= DIV_CW'(SUM_BITS - 1);
                end
                pdc_pkg::ST_DIV: begin
                    r_rem     <= div_q ? alu_y[COUNT_BITS:0] : div_shift;
                    r_run_sum <= div_next;
                    r_div_cnt <= r_div_cnt - DIV_CW'(1);
                    if (r_div_cnt == '0) r_res_avg <= avg_wide[31:0];
                end
                pdc_pkg::ST_THR_DIFF: begin
                    r_acc  <= alu_y[31:0];
                    r_flag <= !alu_ge;
                end
                pdc_pkg::ST_THR_ADD: r_cand <= alu_y[31:0];
                pdc_pkg::ST_THR_INC: r_cand <= alu_y[32] ? 32'hFFFF_FFFF : alu_y[31:0];
                pdc_pkg::ST_APPLY: begin
                    r_thr         <= r_cand;
                    r_raw_dec     <= !alu_ge;
                    r_present     <= !alu_ge;
                    r_last_change <= r_ms;
                end
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    logic        r_out_valid;
    logic        r_out_present, r_out_raw, r_out_cal, r_out_ok, r_out_refused;
    logic [1:0]  r_out_event;
    logic [31:0] r_out_thr, r_out_min, r_out_max, r_out_avg;
    logic [16:0] r_out_count;

    assign cnt_wide = {17'd0, r_res_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_present <= r_present;
            r_out_raw     <= r_raw_dec;
            r_out_event   <= r_event;
            r_out_cal     <= r_cal_run;
            r_out_thr     <= r_thr;
            r_out_ok      <= r_res_ok;
            r_out_min     <= 32'(r_res_min);
            r_out_max     <= 32'(r_res_max);
            r_out_avg     <= r_res_avg;
            r_out_count   <= cnt_wide[16:0];
            r_out_refused <= r_refused;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_present       = r_out_present;
    assign o_raw_present   = r_out_raw;
    assign o_event_code    = r_out_event;
    assign o_calibrating   = r_out_cal;
    assign o_threshold_now = r_out_thr;
    assign o_cal_ok        = r_out_ok;
    assign o_cal_min       = r_out_min;
    assign o_cal_max       = r_out_max;
    assign o_cal_avg       = r_out_avg;
    assign o_cal_samples   = r_out_count;
    assign o_start_refused = r_out_refused;

endmodule
